// ----- hdl/tsf_pkg.sv -----
// shared constants and types for the touch sample trimmed mean filter
`timescale 1ns / 1ps
`default_nettype none

package tsf_pkg;

    // samples averaged per window
    localparam int WINDOW_SIZE = 3;
    localparam int IDX_W       = $clog2(WINDOW_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SIZE - 1);

    localparam int COORD_W = 12;
    localparam int PRESS_W = 16;
    localparam int JIT_W   = 8;
    localparam int SUM_W   = COORD_W + $clog2(WINDOW_SIZE);

    // restoring divider: 24 bit dividend, 12 bit divisor
    localparam int DIV_W     = 2 * COORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    // divisors of the trimmed mean
    localparam logic [COORD_W-1:0] DEN_ONE_DROPPED = COORD_W'(WINDOW_SIZE - 1);
    localparam logic [COORD_W-1:0] DEN_TWO_DROPPED = COORD_W'(WINDOW_SIZE - 2);

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_RAW_MIN_X  = 3'd0,
        REG_RAW_MAX_X  = 3'd1,
        REG_RAW_MIN_Y  = 3'd2,
        REG_RAW_MAX_Y  = 3'd3,
        REG_SCREEN_W   = 3'd4,
        REG_SCREEN_H   = 3'd5,
        REG_JITTER     = 3'd6
    } cfg_reg_t;

    localparam logic [COORD_W-1:0] RST_RAW_MIN_X = 12'd116;
    localparam logic [COORD_W-1:0] RST_RAW_MAX_X = 12'd3974;
    localparam logic [COORD_W-1:0] RST_RAW_MIN_Y = 12'd240;
    localparam logic [COORD_W-1:0] RST_RAW_MAX_Y = 12'd3980;
    localparam logic [COORD_W-1:0] RST_SCREEN_W  = 12'd800;
    localparam logic [COORD_W-1:0] RST_SCREEN_H  = 12'd480;
    localparam logic [JIT_W-1:0]   RST_JITTER    = 8'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SCALE_WR,
        ST_SEARCH,
        ST_SUM,
        ST_AVG_LOAD,
        ST_AVG_WR,
        ST_JITTER,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/touch_sample_trimmed_mean_filter.sv -----
// touch sample scaler and trimmed mean filter, top level
// paths: a release beat goes straight to the result register; a pressed beat is scaled on both
//   axes (two 24-step divides); a window-closing beat adds search, sum and two divides for the mean
// one beat at a time: the next beat is taken only after the result of the last is registered;
//   the shared 24-step restoring divider serves both the scaling and the mean
// reset: async active low, config registers return to their defaults, window empty,
//   held position zero, pen released, no result pending
`timescale 1ns / 1ps
`default_nettype none

module touch_sample_trimmed_mean_filter (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration write port
    input  wire logic                        cfg_we,
    input  wire logic [2:0]                  cfg_index,
    input  wire logic [tsf_pkg::COORD_W-1:0] cfg_data,
    // sample input channel
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tsf_pkg::COORD_W-1:0] sample_x,
    input  wire logic [tsf_pkg::COORD_W-1:0] sample_y,
    input  wire logic [tsf_pkg::PRESS_W-1:0] sample_pressure,
    // result channel
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [tsf_pkg::COORD_W-1:0]      pos_x,
    output logic [tsf_pkg::COORD_W-1:0]      pos_y,
    output logic                             pen_down,
    output logic                             window_done
);

    localparam int CW = tsf_pkg::COORD_W;
    localparam int IW = tsf_pkg::IDX_W;
    localparam int SW = tsf_pkg::SUM_W;
    localparam int DW = tsf_pkg::DIV_W;

    // configuration registers
    logic [CW-1:0]             raw_min_x_reg, raw_max_x_reg;
    logic [CW-1:0]             raw_min_y_reg, raw_max_y_reg;
    logic [CW-1:0]             screen_w_reg, screen_h_reg;
    logic [tsf_pkg::JIT_W-1:0] jitter_reg;

    // sequencer and datapath
    tsf_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic            axis_reg, axis_next;          // 0 works on x, 1 on y
    logic            avg_reg, avg_next;            // divider serves the mean, not scaling
    logic            zero_reg, zero_next;          // scaled value forced to zero
    logic [IW-1:0]   count_reg, count_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   max_i_reg, max_i_next, min_i_reg, min_i_next;
    logic [CW-1:0]   max_v_reg, max_v_next, min_v_reg, min_v_next;
    logic [SW-1:0]   sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [CW-1:0]   avg_x_reg, avg_x_next, avg_y_reg, avg_y_next;
    logic [CW-1:0]   held_x_reg, held_x_next, held_y_reg, held_y_next;
    logic            pressed_reg, pressed_next;
    logic            done_reg, done_next;

    // shared restoring divider
    logic [DW-1:0]                   quo_reg, quo_next;
    logic [CW-1:0]                   rem_reg, rem_next;
    logic [CW-1:0]                   den_reg, den_next;
    logic [tsf_pkg::DIV_CNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [CW:0]                     trial;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic          pen_reg, pen_next, wdone_reg, wdone_next;

    // window store, one entry per sample
    logic [CW-1:0] store_x [tsf_pkg::WINDOW_SIZE];
    logic [CW-1:0] store_y [tsf_pkg::WINDOW_SIZE];
    logic          store_we;
    logic [CW-1:0] store_wdata;
    logic [CW-1:0] rd_x, rd_y;

    // per-axis operand selection
    logic [CW-1:0]   raw_sel, lo_sel, hi_sel, size_sel, size_m1;
    logic [CW-1:0]   diff_raw;
    logic [DW-1:0]   product;
    logic [CW-1:0]   diff_hx, diff_hy;

    assign in_ready    = (state_reg == tsf_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign pen_down    = pen_reg;
    assign window_done = wdone_reg;

    assign rd_x = store_x[idx_reg];
    assign rd_y = store_y[idx_reg];

    assign raw_sel  = axis_reg ? sy_reg        : sx_reg;
    assign lo_sel   = axis_reg ? raw_min_y_reg : raw_min_x_reg;
    assign hi_sel   = axis_reg ? raw_max_y_reg : raw_max_x_reg;
    assign size_sel = axis_reg ? screen_h_reg  : screen_w_reg;
    assign size_m1  = size_sel - CW'(1);
    assign diff_raw = raw_sel - lo_sel;
    // single 12x12 multiplier, result registered into the divider
    assign product  = {{CW{1'b0}}, diff_raw} * {{CW{1'b0}}, size_sel};

    // one restoring step: bring down next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[DW-1]};

    assign diff_hx = (held_x_reg > avg_x_reg) ? held_x_reg - avg_x_reg
                                              : avg_x_reg - held_x_reg;
    assign diff_hy = (held_y_reg > avg_y_reg) ? held_y_reg - avg_y_reg
                                              : avg_y_reg - held_y_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_min_x_reg <= tsf_pkg::RST_RAW_MIN_X;
            raw_max_x_reg <= tsf_pkg::RST_RAW_MAX_X;
            raw_min_y_reg <= tsf_pkg::RST_RAW_MIN_Y;
            raw_max_y_reg <= tsf_pkg::RST_RAW_MAX_Y;
            screen_w_reg  <= tsf_pkg::RST_SCREEN_W;
            screen_h_reg  <= tsf_pkg::RST_SCREEN_H;
            jitter_reg    <= tsf_pkg::RST_JITTER;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsf_pkg::REG_RAW_MIN_X: raw_min_x_reg <= cfg_data;
                tsf_pkg::REG_RAW_MAX_X: raw_max_x_reg <= cfg_data;
                tsf_pkg::REG_RAW_MIN_Y: raw_min_y_reg <= cfg_data;
                tsf_pkg::REG_RAW_MAX_Y: raw_max_y_reg <= cfg_data;
                tsf_pkg::REG_SCREEN_W:  screen_w_reg  <= cfg_data;
                tsf_pkg::REG_SCREEN_H:  screen_h_reg  <= cfg_data;
                tsf_pkg::REG_JITTER:    jitter_reg    <= cfg_data[tsf_pkg::JIT_W-1:0];
                default:                ;  // unmapped index, write dropped
            endcase
        end
    end

    // window store writes, no reset: only entries of the current window are read
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            if (axis_reg)
                store_y[count_reg] <= store_wdata;
            else
                store_x[count_reg] <= store_wdata;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsf_pkg::ST_IDLE;
            count_reg     <= '0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            pressed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            pressed_reg   <= pressed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        axis_reg  <= axis_next;
        avg_reg   <= avg_next;
        zero_reg  <= zero_next;
        idx_reg   <= idx_next;
        max_i_reg <= max_i_next;
        min_i_reg <= min_i_next;
        max_v_reg <= max_v_next;
        min_v_reg <= min_v_next;
        sum_x_reg <= sum_x_next;
        sum_y_reg <= sum_y_next;
        avg_x_reg <= avg_x_next;
        avg_y_reg <= avg_y_next;
        done_reg  <= done_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        dcnt_reg  <= dcnt_next;
        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
        pen_reg   <= pen_next;
        wdone_reg <= wdone_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        axis_next      = axis_reg;
        avg_next       = avg_reg;
        zero_next      = zero_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        max_i_next     = max_i_reg;
        min_i_next     = min_i_reg;
        max_v_next     = max_v_reg;
        min_v_next     = min_v_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        avg_x_next     = avg_x_reg;
        avg_y_next     = avg_y_reg;
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        pressed_next   = pressed_reg;
        done_next      = done_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        dcnt_next      = dcnt_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pen_next       = pen_reg;
        wdone_next     = wdone_reg;
        store_we       = 1'b0;
        store_wdata    = '0;

        // result beat leaves when taken
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            tsf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    sx_next   = sample_x;
                    sy_next   = sample_y;
                    axis_next = 1'b0;
                    avg_next  = 1'b0;
                    done_next = 1'b0;
                    if (sample_pressure == '0)
                    begin
                        // pen released: empty the window, keep the held position
                        count_next   = '0;
                        pressed_next = 1'b0;
                        state_next   = tsf_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = tsf_pkg::ST_MUL;
                    end
                end
            end

            tsf_pkg::ST_MUL:
            begin
                zero_next  = (raw_sel <= lo_sel) || (hi_sel <= lo_sel) || (size_sel == '0);
                quo_next   = product;
                rem_next   = '0;
                den_next   = hi_sel - lo_sel;
                dcnt_next  = '0;
                state_next = tsf_pkg::ST_DIV;
            end

            tsf_pkg::ST_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = CW'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CW-1:0];
                    quo_next = {quo_reg[DW-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == tsf_pkg::DIV_LAST)
                    state_next = avg_reg ? tsf_pkg::ST_AVG_WR : tsf_pkg::ST_SCALE_WR;
            end

            tsf_pkg::ST_SCALE_WR:
            begin
                store_we = 1'b1;
                if (zero_reg)
                    store_wdata = '0;
                else if (quo_reg > {{CW{1'b0}}, size_m1})
                    store_wdata = size_m1;
                else
                    store_wdata = quo_reg[CW-1:0];

                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = tsf_pkg::ST_MUL;
                end
                else if (count_reg == tsf_pkg::LAST_IDX)
                begin
                    // window full: filter it
                    count_next   = '0;
                    pressed_next = 1'b1;
                    idx_next     = '0;
                    state_next   = tsf_pkg::ST_SEARCH;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = tsf_pkg::ST_FINISH;
                end
            end

            tsf_pkg::ST_SEARCH:
            begin
                // first largest and first smallest x win on ties
                if (idx_reg == '0)
                begin
                    max_v_next = rd_x;
                    min_v_next = rd_x;
                    max_i_next = '0;
                    min_i_next = '0;
                end
                else
                begin
                    if (rd_x > max_v_reg)
                    begin
                        max_v_next = rd_x;
                        max_i_next = idx_reg;
                    end
                    if (rd_x < min_v_reg)
                    begin
                        min_v_next = rd_x;
                        min_i_next = idx_reg;
                    end
                end
                if (idx_reg == tsf_pkg::LAST_IDX)
                begin
                    idx_next   = '0;
                    sum_x_next = '0;
                    sum_y_next = '0;
                    state_next = tsf_pkg::ST_SUM;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            tsf_pkg::ST_SUM:
            begin
                if (idx_reg != max_i_reg && idx_reg != min_i_reg)
                begin
                    sum_x_next = sum_x_reg + SW'(rd_x);
                    sum_y_next = sum_y_reg + SW'(rd_y);
                end
                if (idx_reg == tsf_pkg::LAST_IDX)
                begin
                    axis_next  = 1'b0;
                    avg_next   = 1'b1;
                    state_next = tsf_pkg::ST_AVG_LOAD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            tsf_pkg::ST_AVG_LOAD:
            begin
                quo_next   = axis_reg ? DW'(sum_y_reg) : DW'(sum_x_reg);
                rem_next   = '0;
                den_next   = (max_i_reg == min_i_reg) ? tsf_pkg::DEN_ONE_DROPPED
                                                      : tsf_pkg::DEN_TWO_DROPPED;
                dcnt_next  = '0;
                state_next = tsf_pkg::ST_DIV;
            end

            tsf_pkg::ST_AVG_WR:
            begin
                if (!axis_reg)
                begin
                    avg_x_next = quo_reg[CW-1:0];
                    axis_next  = 1'b1;
                    state_next = tsf_pkg::ST_AVG_LOAD;
                end
                else
                begin
                    avg_y_next = quo_reg[CW-1:0];
                    state_next = tsf_pkg::ST_JITTER;
                end
            end

            tsf_pkg::ST_JITTER:
            begin
                // move only if either axis changed by more than the threshold
                if (diff_hx > CW'(jitter_reg) || diff_hy > CW'(jitter_reg))
                begin
                    held_x_next = avg_x_reg;
                    held_y_next = avg_y_reg;
                end
                done_next  = 1'b1;
                state_next = tsf_pkg::ST_FINISH;
            end

            tsf_pkg::ST_FINISH:
            begin
                // load result register once the previous beat has left
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    pos_x_next     = held_x_reg;
                    pos_y_next     = held_y_reg;
                    pen_next       = pressed_reg;
                    wdone_next     = done_reg;
                    state_next     = tsf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tsf_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // a finished window always reports the pen as down
    a_done_implies_pen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && window_done |-> pen_down)
        else $error("window_done without pen_down");

    // a released sample goes straight to the result stage with the pen up
    a_release_path: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && sample_pressure == '0
        |=> state_reg == tsf_pkg::ST_FINISH && !pressed_reg && count_reg == '0)
        else $error("release did not empty the window");

    // the window fill never reaches the window size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tsf_pkg::LAST_IDX)
        else $error("sample count out of range");

    // the divider is only left after its last step
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tsf_pkg::ST_DIV && state_next != tsf_pkg::ST_DIV
        |-> dcnt_reg == tsf_pkg::DIV_LAST)
        else $error("divider left early");

    // the result register is never overwritten while a beat is pending
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pos_x) && $stable(pos_y) && out_valid)
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ----- tb/touch_sample_trimmed_mean_filter_tb.sv -----
// testbench for the touch sample trimmed mean filter: directed and random strokes against a predictor
`timescale 1ns / 1ps

module touch_sample_trimmed_mean_filter_tb;

    // one result beat as the block presents it
    typedef struct packed {
        logic [tsf_pkg::COORD_W-1:0] pos_x;
        logic [tsf_pkg::COORD_W-1:0] pos_y;
        logic                        pen_down;
        logic                        window_done;
    } position_beat_t;

    // dut ports
    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [2:0]                  cfg_index;
    logic [tsf_pkg::COORD_W-1:0] cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [tsf_pkg::COORD_W-1:0] sample_x;
    logic [tsf_pkg::COORD_W-1:0] sample_y;
    logic [tsf_pkg::PRESS_W-1:0] sample_pressure;
    logic                        out_valid;
    logic                        out_ready;
    logic [tsf_pkg::COORD_W-1:0] pos_x;
    logic [tsf_pkg::COORD_W-1:0] pos_y;
    logic                        pen_down;
    logic                        window_done;

    // positions predicted for accepted samples, oldest first
    position_beat_t pending_positions[$];
    int unsigned    errors = 0;
    // when set, neither side idles
    bit             no_idle = 1'b0;

    // predictor copy of the calibration registers, starting at reset values
    logic [tsf_pkg::COORD_W-1:0] cal_min_x  = tsf_pkg::RST_RAW_MIN_X;
    logic [tsf_pkg::COORD_W-1:0] cal_max_x  = tsf_pkg::RST_RAW_MAX_X;
    logic [tsf_pkg::COORD_W-1:0] cal_min_y  = tsf_pkg::RST_RAW_MIN_Y;
    logic [tsf_pkg::COORD_W-1:0] cal_max_y  = tsf_pkg::RST_RAW_MAX_Y;
    logic [tsf_pkg::COORD_W-1:0] cal_width  = tsf_pkg::RST_SCREEN_W;
    logic [tsf_pkg::COORD_W-1:0] cal_height = tsf_pkg::RST_SCREEN_H;
    logic [tsf_pkg::JIT_W-1:0]   cal_jitter = tsf_pkg::RST_JITTER;

    // predictor copy of the window and the held position
    logic [tsf_pkg::COORD_W-1:0] win_x [tsf_pkg::WINDOW_SIZE];
    logic [tsf_pkg::COORD_W-1:0] win_y [tsf_pkg::WINDOW_SIZE];
    int unsigned                 fill_count = 0;
    logic [tsf_pkg::COORD_W-1:0] held_x     = '0;
    logic [tsf_pkg::COORD_W-1:0] held_y     = '0;
    logic                        pen_state  = 1'b0;

    touch_sample_trimmed_mean_filter dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample_x        (sample_x),
        .sample_y        (sample_y),
        .sample_pressure (sample_pressure),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pen_down        (pen_down),
        .window_done     (window_done)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // raw converter units to pixels, clamped to the screen
    function automatic logic [tsf_pkg::COORD_W-1:0] scale_to_pixels(int unsigned raw,
                                                                    int unsigned lo,
                                                                    int unsigned hi,
                                                                    int unsigned size);
        int unsigned v;
        // below the edge, a broken calibration or a zero-size screen all give pixel 0
        if (raw <= lo || hi <= lo || size == 0)
            return '0;
        v = (raw - lo) * size / (hi - lo);
        if (v > size - 1)
            v = size - 1;
        return v[tsf_pkg::COORD_W-1:0];
    endfunction

    // advance the predicted filter by one accepted sample, return the beat it causes
    function automatic position_beat_t predict_position(logic [tsf_pkg::COORD_W-1:0] x,
                                                        logic [tsf_pkg::COORD_W-1:0] y,
                                                        logic [tsf_pkg::PRESS_W-1:0] p);
        position_beat_t beat;
        int unsigned    max_i, min_i, sum_x, sum_y, n, ax, ay, dx, dy;
        logic [tsf_pkg::COORD_W-1:0] max_v, min_v;
        beat.window_done = 1'b0;
        if (p == '0)
        begin
            // pen release: window emptied, held position kept
            fill_count = 0;
            pen_state  = 1'b0;
        end
        else
        begin
            if (fill_count >= tsf_pkg::WINDOW_SIZE)
                fill_count = 0;
            win_x[fill_count] = scale_to_pixels(x, cal_min_x, cal_max_x, cal_width);
            win_y[fill_count] = scale_to_pixels(y, cal_min_y, cal_max_y, cal_height);
            fill_count++;
            if (fill_count >= tsf_pkg::WINDOW_SIZE)
            begin
                pen_state = 1'b1;
                // first largest and first smallest x win ties
                max_i = 0;
                min_i = 0;
                max_v = win_x[0];
                min_v = win_x[0];
                for (int i = 1; i < tsf_pkg::WINDOW_SIZE; i++)
                begin
                    if (win_x[i] > max_v)
                    begin
                        max_v = win_x[i];
                        max_i = i;
                    end
                    if (win_x[i] < min_v)
                    begin
                        min_v = win_x[i];
                        min_i = i;
                    end
                end
                sum_x = 0;
                sum_y = 0;
                for (int i = 0; i < tsf_pkg::WINDOW_SIZE; i++)
                begin
                    if (i != max_i && i != min_i)
                    begin
                        sum_x += win_x[i];
                        sum_y += win_y[i];
                    end
                end
                // all x equal: only one sample is dropped
                n  = (max_i == min_i) ? tsf_pkg::WINDOW_SIZE - 1 : tsf_pkg::WINDOW_SIZE - 2;
                ax = (sum_x / n) & 32'hFFF;
                ay = (sum_y / n) & 32'hFFF;
                dx = (held_x > ax) ? held_x - ax : ax - held_x;
                dy = (held_y > ay) ? held_y - ay : ay - held_y;
                // move only past the jitter threshold on either axis
                if (dx > cal_jitter || dy > cal_jitter)
                begin
                    held_x = ax[tsf_pkg::COORD_W-1:0];
                    held_y = ay[tsf_pkg::COORD_W-1:0];
                end
                fill_count       = 0;
                beat.window_done = 1'b1;
            end
        end
        beat.pos_x    = held_x;
        beat.pos_y    = held_y;
        beat.pen_down = pen_state;
        return beat;
    endfunction

    // raw reading scattered around a stroke center, kept in converter range
    function automatic logic [tsf_pkg::COORD_W-1:0] near_raw(int center, int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[tsf_pkg::COORD_W-1:0];
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // send one sample beat; called and returns at a falling edge
    task automatic send_sample(logic [tsf_pkg::COORD_W-1:0] x, logic [tsf_pkg::COORD_W-1:0] y,
                               logic [tsf_pkg::PRESS_W-1:0] p);
        // random sender gap before the beat
        if (!no_idle && $urandom_range(0, 99) < 25)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        sample_x        = x;
        sample_y        = y;
        sample_pressure = p;
        in_valid        = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // beat taken at this edge: predict its result now, in acceptance order
        pending_positions.push_back(predict_position(x, y, p));
        @(negedge clk);
    endtask

    // stop sending and let every expected beat come back; the block is idle after
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_positions.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(tsf_pkg::cfg_reg_t idx, logic [tsf_pkg::COORD_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            tsf_pkg::REG_RAW_MIN_X: cal_min_x  = data;
            tsf_pkg::REG_RAW_MAX_X: cal_max_x  = data;
            tsf_pkg::REG_RAW_MIN_Y: cal_min_y  = data;
            tsf_pkg::REG_RAW_MAX_Y: cal_max_y  = data;
            tsf_pkg::REG_SCREEN_W:  cal_width  = data;
            tsf_pkg::REG_SCREEN_H:  cal_height = data;
            tsf_pkg::REG_JITTER:    cal_jitter = data[tsf_pkg::JIT_W-1:0];
            default:                ;
        endcase
    endtask

    // drain, then rewrite the whole calibration set
    task automatic program_calibration(logic [tsf_pkg::COORD_W-1:0] min_x,
                                       logic [tsf_pkg::COORD_W-1:0] max_x,
                                       logic [tsf_pkg::COORD_W-1:0] min_y,
                                       logic [tsf_pkg::COORD_W-1:0] max_y,
                                       logic [tsf_pkg::COORD_W-1:0] width,
                                       logic [tsf_pkg::COORD_W-1:0] height,
                                       logic [tsf_pkg::COORD_W-1:0] jitter);
        wait_idle();
        write_reg(tsf_pkg::REG_RAW_MIN_X, min_x);
        write_reg(tsf_pkg::REG_RAW_MAX_X, max_x);
        write_reg(tsf_pkg::REG_RAW_MIN_Y, min_y);
        write_reg(tsf_pkg::REG_RAW_MAX_Y, max_y);
        write_reg(tsf_pkg::REG_SCREEN_W, width);
        write_reg(tsf_pkg::REG_SCREEN_H, height);
        write_reg(tsf_pkg::REG_JITTER, jitter);
    endtask

    // reset calibration: release, clamping at both raw extremes, release mid window
    task automatic test_release_and_defaults();
        send_sample(12'd4095, 12'd4095, 16'd0);
        // below minimum, beyond maximum, middle
        send_sample(12'd0, 12'd0, 16'd1);
        send_sample(12'd4095, 12'd4095, 16'hFFFF);
        send_sample(12'd2000, 12'd2000, 16'h8000);
        // one pressed sample, then the pen lifts before the window fills
        send_sample(12'd3000, 12'd100, 16'd77);
        send_sample(12'd3000, 12'd100, 16'd0);
        // raw exactly at the minimum and exactly at the maximum
        send_sample(12'd116, 12'd240, 16'd500);
        send_sample(12'd3974, 12'd3980, 16'd500);
        send_sample(12'd1000, 12'd1000, 16'd500);
        wait_idle();
    endtask

    // trimming ties and the jitter hold
    task automatic test_window_trim();
        // all x equal: largest and smallest are the same sample
        send_sample(12'd1000, 12'd300, 16'd9);
        send_sample(12'd1000, 12'd2000, 16'd9);
        send_sample(12'd1000, 12'd3500, 16'd9);
        // two samples share the largest x, then two share the smallest
        send_sample(12'd3000, 12'd400, 16'd9);
        send_sample(12'd3000, 12'd900, 16'd9);
        send_sample(12'd500, 12'd1400, 16'd9);
        send_sample(12'd500, 12'd1500, 16'd9);
        send_sample(12'd3000, 12'd2500, 16'd9);
        send_sample(12'd500, 12'd3500, 16'd9);
        // tiny move that stays inside the jitter threshold
        send_sample(12'd500, 12'd3500, 16'd9);
        send_sample(12'd501, 12'd3501, 16'd9);
        send_sample(12'd502, 12'd3502, 16'd9);
        wait_idle();
    endtask

    // broken calibration, zero-size screen, largest screen
    task automatic test_calibration_edges();
        // x maximum below minimum, y maximum equal to minimum, zero width
        program_calibration(12'd4095, 12'd0, 12'd2000, 12'd2000, 12'd0, 12'd4095, 12'd255);
        send_sample(12'd4095, 12'd4095, 16'd3);
        send_sample(12'd0, 12'd2001, 16'd3);
        send_sample(12'd2000, 12'd1999, 16'd3);
        // full range, widest screen, one-pixel height, no jitter tolerance
        program_calibration(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd1, 12'd0);
        send_sample(12'd4095, 12'd4095, 16'd3);
        send_sample(12'd4095, 12'd0, 16'd3);
        send_sample(12'd4094, 12'd2048, 16'd3);
        wait_idle();
    endtask

    // random strokes over several calibration settings
    task automatic test_random_strokes();
        int cx, cy, spread, kind, r;
        logic [tsf_pkg::COORD_W-1:0] sx, sy;
        logic [tsf_pkg::PRESS_W-1:0] sp;
        for (int phase = 0; phase < 6; phase++)
        begin
            kind = (phase == 1) ? 1 : (phase == 3) ? 2 : (phase == 4) ? 3 : 0;
            case (kind)
                // realistic panel: min well below max
                0: program_calibration(12'($urandom_range(0, 1000)),
                                       12'($urandom_range(3000, 4095)),
                                       12'($urandom_range(0, 1000)),
                                       12'($urandom_range(3000, 4095)),
                                       12'($urandom_range(1, 4095)),
                                       12'($urandom_range(1, 4095)),
                                       12'($urandom_range(0, 40)));
                1: program_calibration(12'd0, 12'd4095, 12'd0, 12'd4095,
                                       12'd4095, 12'd4095, 12'd0);
                // one raw step spans the screen, one-pixel screen, widest jitter
                2: program_calibration(12'd4094, 12'd4095, 12'd4094, 12'd4095,
                                       12'd1, 12'd1, 12'd255);
                // anything the registers hold, upper jitter bits included
                default: program_calibration(12'($urandom), 12'($urandom), 12'($urandom),
                                             12'($urandom), 12'($urandom), 12'($urandom),
                                             12'($urandom));
            endcase
            // one long phase with both sides always ready
            no_idle = (phase == 2);
            cx      = $urandom_range(0, 4095);
            cy      = $urandom_range(0, 4095);
            spread  = 24;
            for (int k = 0; k < 240; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                begin
                    // pen lift, next stroke starts elsewhere
                    sx = 12'($urandom);
                    sy = 12'($urandom);
                    sp = '0;
                    cx = $urandom_range(0, 4095);
                    cy = $urandom_range(0, 4095);
                    case ($urandom_range(0, 2))
                        0:       spread = 2;
                        1:       spread = 24;
                        default: spread = 300;
                    endcase
                end
                else if (r < 16)
                begin
                    // noise: any reading, pressure possibly zero
                    sx = 12'($urandom);
                    sy = 12'($urandom);
                    sp = 16'($urandom);
                end
                else
                begin
                    // pressed sample near the stroke, which drifts slowly
                    sx = near_raw(cx, spread);
                    sy = near_raw(cy, spread);
                    sp = 16'($urandom_range(1, 65535));
                    if ($urandom_range(0, 9) == 0)
                    begin
                        cx = near_raw(cx, 200);
                        cy = near_raw(cy, 200);
                    end
                end
                send_sample(sx, sy, sp);
            end
        end
        no_idle = 1'b0;
        wait_idle();
    endtask

    // receiver: random stalls, driven at the falling edge
    always @(negedge clk)
    begin
        out_ready = no_idle || ($urandom_range(0, 99) >= 25);
    end

    // compare every accepted result beat with the oldest prediction
    always @(posedge clk)
    begin : check_results
        position_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_positions.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none actual %0d %0d %0b %0b",
                         $time, pos_x, pos_y, pen_down, window_done);
                errors++;
            end
            else
            begin
                want = pending_positions.pop_front();
                check_field("pos_x", want.pos_x, pos_x);
                check_field("pos_y", want.pos_y, pos_y);
                check_field("pen_down", want.pen_down, pen_down);
                check_field("window_done", want.window_done, window_done);
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = tsf_pkg::REG_RAW_MIN_X;
        cfg_data        = '0;
        in_valid        = 1'b0;
        sample_x        = '0;
        sample_y        = '0;
        sample_pressure = '0;
        out_ready       = 1'b0;
        for (int i = 0; i < tsf_pkg::WINDOW_SIZE; i++)
        begin
            win_x[i] = '0;
            win_y[i] = '0;
        end
        // reset held low, then released at a falling edge
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_release_and_defaults();
        test_window_trim();
        test_calibration_edges();
        test_random_strokes();

        // everything is back; watch a little longer for stray beats
        wait_idle();
        repeat (150) @(posedge clk);
        if (errors == 0 && pending_positions.size() == 0)
            $display("touch_sample_trimmed_mean_filter regression: pass");
        else
            $display("touch_sample_trimmed_mean_filter regression: fail");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("touch_sample_trimmed_mean_filter regression: fail");
        $finish;
    end

endmodule
